/* hdl/btpc_pkg.sv */
// Shared types, constants and arithmetic helpers for the barometric
// compensation pipeline. No dependencies.
package btpc_pkg;

    localparam logic [63:0] OFFSET_FINE  = 64'd128000;
    localparam logic [63:0] DIV_SCALE    = 64'd3125;
    localparam logic [63:0] RAW_FULL     = 64'd1048576;
    localparam int          P1_BIAS_SH   = 47;
    localparam int          P1_SH        = 33;
    localparam int          P4_SH        = 35;
    localparam int          P5_SH        = 17;
    localparam int          FRONT_STAGES = 12;
    localparam int          DIV_STAGES   = 64;
    localparam int          BACK_STAGES  = 7;

    typedef enum logic [2:0] {
        REG_T1    = 3'd0,
        REG_T23   = 3'd1,
        REG_P12   = 3'd2,
        REG_P34   = 3'd3,
        REG_P56   = 3'd4,
        REG_P78   = 3'd5,
        REG_P9    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [63:0] p3;
        logic [63:0] p4;
        logic [63:0] p5;
        logic [63:0] p6;
        logic [63:0] p7;
        logic [63:0] p8;
        logic [63:0] p9;
    } t_coef;

    // Partial products of a 64x64 multiply, low 64 bits kept.
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_mp;

    typedef struct packed {
        logic [21:0] temp;
        logic        zero;
        logic        qneg;
        logic [63:0] rem;
        logic [63:0] qn;
        logic [63:0] den;
    } t_dv;

    typedef struct packed {
        logic [21:0] temp;
        logic [31:0] press;
        logic        zero;
    } t_res;

    function automatic t_mp mp_parts(input logic [63:0] a, input logic [63:0] b);
        t_mp r;
        r.ll = a[31:0] * b[31:0];
        r.lh = a[31:0] * b[63:32];
        r.hl = a[63:32] * b[31:0];
        return r;
    endfunction

    function automatic logic [63:0] mp_comb(input t_mp m);
        logic [31:0] mid;
        mid = m.lh + m.hl;
        return m.ll + {mid, 32'd0};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

endpackage

/* hdl/btpc_front.sv */
// Front pipeline: temperature polynomial and pressure divisor / dividend.
// Depends on btpc_pkg.
module btpc_front import btpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    input  t_coef       i_coef,
    output logic        o_valid,
    output t_dv         o_data
);

    typedef struct packed {
        logic [19:0] at;
        logic [19:0] ap;
        logic [31:0] pat2;
        logic [31:0] dd;
        logic [31:0] v1;
        logic [31:0] m;
        logic [21:0] temp;
        logic [63:0] w1;
        logic [63:0] pp;
        t_mp         msq;
        t_mp         m5;
        t_mp         m2;
        logic [63:0] sq;
        logic [63:0] c;
        logic [63:0] e;
        t_mp         m6;
        t_mp         m3;
        logic [63:0] w2;
        logic [63:0] f;
        logic [63:0] n0;
        t_mp         m1;
        t_mp         mn;
        logic [63:0] w1b;
        logic [63:0] num;
        logic [63:0] ua;
        logic [63:0] ub;
        logic        qneg;
        logic        zero;
    } t_front;

    localparam int NS = FRONT_STAGES;

    t_front           r_fs [NS];
    t_front           n_fs [NS];
    logic [NS-1:0]    r_fv;
    logic [31:0]      s_a;
    logic [31:0]      s_d;
    logic [31:0]      s_fine;
    logic [31:0]      s_t5;
    logic [31:0]      s_tc;

    always_comb begin
        n_fs[0]    = r_fs[0];
        n_fs[0].at = i_raw_temperature;
        n_fs[0].ap = i_raw_pressure;

        n_fs[1]      = r_fs[0];
        s_a          = 32'(r_fs[0].at >> 3) - {15'd0, i_coef.t1, 1'b0};
        s_d          = 32'(r_fs[0].at >> 4) - {16'd0, i_coef.t1};
        n_fs[1].pat2 = s_a * i_coef.t2;
        n_fs[1].dd   = s_d * s_d;

        n_fs[2]    = r_fs[1];
        n_fs[2].v1 = asr32(r_fs[1].pat2, 11);
        n_fs[2].m  = asr32(r_fs[1].dd, 12) * i_coef.t3;

        // fine*5 as shift-add, then round and scale to centidegrees
        n_fs[3]      = r_fs[2];
        s_fine       = r_fs[2].v1 + asr32(r_fs[2].m, 14);
        s_t5         = {s_fine[29:0], 2'b00} + s_fine + 32'd128;
        s_tc         = asr32(s_t5, 8);
        n_fs[3].temp = s_tc[21:0];
        n_fs[3].w1   = {{32{s_fine[31]}}, s_fine} - OFFSET_FINE;
        n_fs[3].pp   = RAW_FULL - {44'd0, r_fs[2].ap};

        n_fs[4]     = r_fs[3];
        n_fs[4].msq = mp_parts(r_fs[3].w1, r_fs[3].w1);
        n_fs[4].m5  = mp_parts(r_fs[3].w1, i_coef.p5);
        n_fs[4].m2  = mp_parts(r_fs[3].w1, i_coef.p2);

        n_fs[5]    = r_fs[4];
        n_fs[5].sq = mp_comb(r_fs[4].msq);
        n_fs[5].c  = (mp_comb(r_fs[4].m5) << P5_SH) + (i_coef.p4 << P4_SH);
        n_fs[5].e  = mp_comb(r_fs[4].m2) << 12;

        n_fs[6]    = r_fs[5];
        n_fs[6].m6 = mp_parts(r_fs[5].sq, i_coef.p6);
        n_fs[6].m3 = mp_parts(r_fs[5].sq, i_coef.p3);

        n_fs[7]    = r_fs[6];
        n_fs[7].w2 = mp_comb(r_fs[6].m6) + r_fs[6].c;
        n_fs[7].f  = (64'd1 << P1_BIAS_SH) + asr64(mp_comb(r_fs[6].m3), 8) + r_fs[6].e;

        n_fs[8]    = r_fs[7];
        n_fs[8].n0 = (r_fs[7].pp << 31) - r_fs[7].w2;
        n_fs[8].m1 = mp_parts(r_fs[7].f, i_coef.p1);

        n_fs[9]     = r_fs[8];
        n_fs[9].mn  = mp_parts(r_fs[8].n0, DIV_SCALE);
        n_fs[9].w1b = asr64(mp_comb(r_fs[8].m1), P1_SH);

        n_fs[10]     = r_fs[9];
        n_fs[10].num = mp_comb(r_fs[9].mn);

        // magnitudes and quotient sign for the unsigned divider
        n_fs[11]      = r_fs[10];
        n_fs[11].ua   = r_fs[10].num[63] ? (64'd0 - r_fs[10].num) : r_fs[10].num;
        n_fs[11].ub   = r_fs[10].w1b[63] ? (64'd0 - r_fs[10].w1b) : r_fs[10].w1b;
        n_fs[11].qneg = r_fs[10].num[63] ^ r_fs[10].w1b[63];
        n_fs[11].zero = (r_fs[10].w1b == 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (i_en) begin
            r_fv <= {r_fv[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_fs[k] <= n_fs[k];
            end
        end
    end

    assign o_valid     = r_fv[NS-1];
    assign o_data.temp = r_fs[NS-1].temp;
    assign o_data.zero = r_fs[NS-1].zero;
    assign o_data.qneg = r_fs[NS-1].qneg;
    assign o_data.rem  = 64'd0;
    assign o_data.qn   = r_fs[NS-1].ua;
    assign o_data.den  = r_fs[NS-1].ub;

endmodule

/* hdl/btpc_div.sv */
// Radix-2 restoring divider, one quotient bit per stage.
// Depends on btpc_pkg.
module btpc_div import btpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_dv  i_data,
    output logic o_valid,
    output t_dv  o_data
);

    localparam int NS = DIV_STAGES;

    t_dv           r_dv [NS];
    t_dv           n_dv [NS];
    logic [NS-1:0] r_vv;

    // rem < den <= 2^63, so the shifted remainder still fits 64 bits
    function automatic t_dv div_step(input t_dv s);
        t_dv         r;
        logic [63:0] sh;
        logic        ge;
        r  = s;
        sh = {s.rem[62:0], s.qn[63]};
        ge = (sh >= s.den);
        r.rem = ge ? (sh - s.den) : sh;
        r.qn  = {s.qn[62:0], ge};
        return r;
    endfunction

    always_comb begin
        n_dv[0] = div_step(i_data);
        for (int k = 1; k < NS; k++) begin
            n_dv[k] = div_step(r_dv[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv <= '0;
        end else if (i_en) begin
            r_vv <= {r_vv[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    assign o_valid = r_vv[NS-1];
    assign o_data  = r_dv[NS-1];

endmodule

/* hdl/btpc_back.sv */
// Back pipeline: quotient sign fix and second-order pressure correction.
// Depends on btpc_pkg.
module btpc_back import btpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_dv   i_data,
    input  t_coef i_coef,
    output logic  o_valid,
    output t_res  o_data
);

    typedef struct packed {
        logic [21:0] temp;
        logic        zero;
        logic [63:0] p;
        t_mp         mph;
        t_mp         m8;
        logic [63:0] phph;
        logic [63:0] x2;
        t_mp         m9;
        logic [63:0] x1;
        logic [63:0] s;
        logic [31:0] press;
    } t_back;

    localparam int NS = BACK_STAGES;

    t_back         r_bs [NS];
    t_back         n_bs [NS];
    logic [NS-1:0] r_bv;
    logic [63:0]   s_ph;
    logic [63:0]   s_pr;

    always_comb begin
        n_bs[0]      = r_bs[0];
        n_bs[0].temp = i_data.temp;
        n_bs[0].zero = i_data.zero;
        n_bs[0].p    = i_data.qneg ? (64'd0 - i_data.qn) : i_data.qn;

        n_bs[1]     = r_bs[0];
        s_ph        = asr64(r_bs[0].p, 13);
        n_bs[1].mph = mp_parts(s_ph, s_ph);
        n_bs[1].m8  = mp_parts(i_coef.p8, r_bs[0].p);

        n_bs[2]      = r_bs[1];
        n_bs[2].phph = mp_comb(r_bs[1].mph);
        n_bs[2].x2   = asr64(mp_comb(r_bs[1].m8), 19);

        n_bs[3]    = r_bs[2];
        n_bs[3].m9 = mp_parts(i_coef.p9, r_bs[2].phph);

        n_bs[4]    = r_bs[3];
        n_bs[4].x1 = asr64(mp_comb(r_bs[3].m9), 25);

        n_bs[5]   = r_bs[4];
        n_bs[5].s = r_bs[4].p + r_bs[4].x1 + r_bs[4].x2;

        // zero divisor forces pressure to 0
        n_bs[6]       = r_bs[5];
        s_pr          = asr64(r_bs[5].s, 8) + (i_coef.p7 << 4);
        n_bs[6].press = r_bs[5].zero ? 32'd0 : s_pr[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (i_en) begin
            r_bv <= {r_bv[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_bs[k] <= n_bs[k];
            end
        end
    end

    assign o_valid      = r_bv[NS-1];
    assign o_data.temp  = r_bs[NS-1].temp;
    assign o_data.press = r_bs[NS-1].press;
    assign o_data.zero  = r_bs[NS-1].zero;

endmodule

/* hdl/baro_temp_pressure_compensation.sv */
// Top level of the barometric compensation engine: calibration registers,
// pipeline sections and output skid. Depends on btpc_pkg, btpc_front,
// btpc_div and btpc_back.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+------------------------------------
//  input     | in        | i_valid / o_stall   | i_raw_temperature, i_raw_pressure
//  result    | out       | o_valid / i_stall   | o_temp_centidegrees, o_pressure_q24_8,
//            |           |                     | o_divisor_zero
//  config    | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while o_stall is low, through 12 front stages for the
// polynomials, 64 divider stages (one quotient bit each), 7 back stages and
// the output register.
// Reset (synchronous, active low) clears the calibration words and all
// valid bits. A stalled result moves into a one-entry skid; the pipeline
// holds only while that skid is occupied, so o_stall comes from a register.
module baro_temp_pressure_compensation import btpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [21:0] o_temp_centidegrees,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_divisor_zero,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // calibration words
    logic [15:0] r_t1;
    logic [31:0] r_t23;
    logic [31:0] r_p12;
    logic [31:0] r_p34;
    logic [31:0] r_p56;
    logic [31:0] r_p78;
    logic [15:0] r_p9;

    t_coef s_coef;

    logic  s_en;
    logic  s_fv;
    t_dv   s_fd;
    logic  s_dv;
    t_dv   s_dd;
    logic  s_bv;
    t_res  s_bd;

    logic  r_out_v;
    t_res  r_out;
    logic  r_skid_v;
    t_res  r_skid;

    logic  s_take;
    logic  s_arrive;
    logic  s_out_free;

    // Write calibration registers; out-of-range indexes drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1  <= '0;
            r_t23 <= '0;
            r_p12 <= '0;
            r_p34 <= '0;
            r_p56 <= '0;
            r_p78 <= '0;
            r_p9  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_T1:  r_t1  <= i_cfg_data[15:0];
                REG_T23: r_t23 <= i_cfg_data;
                REG_P12: r_p12 <= i_cfg_data;
                REG_P34: r_p34 <= i_cfg_data;
                REG_P56: r_p56 <= i_cfg_data;
                REG_P78: r_p78 <= i_cfg_data;
                REG_P9:  r_p9  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Unpack into the widths the datapath wants: signed words extended.
    always_comb begin
        s_coef.t1 = r_t1;
        s_coef.t2 = {{16{r_t23[31]}}, r_t23[31:16]};
        s_coef.t3 = {{16{r_t23[15]}}, r_t23[15:0]};
        s_coef.p1 = {48'd0, r_p12[31:16]};
        s_coef.p2 = {{48{r_p12[15]}}, r_p12[15:0]};
        s_coef.p3 = {{48{r_p34[31]}}, r_p34[31:16]};
        s_coef.p4 = {{48{r_p34[15]}}, r_p34[15:0]};
        s_coef.p5 = {{48{r_p56[31]}}, r_p56[31:16]};
        s_coef.p6 = {{48{r_p56[15]}}, r_p56[15:0]};
        s_coef.p7 = {{48{r_p78[31]}}, r_p78[31:16]};
        s_coef.p8 = {{48{r_p78[15]}}, r_p78[15:0]};
        s_coef.p9 = {{48{r_p9[15]}}, r_p9};
    end

    // Advance the whole pipeline unless the skid holds a result.
    assign s_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    btpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (s_en),
        .i_valid           (i_valid),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_coef            (s_coef),
        .o_valid           (s_fv),
        .o_data            (s_fd)
    );

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_fv),
        .i_data  (s_fd),
        .o_valid (s_dv),
        .o_data  (s_dd)
    );

    btpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_dv),
        .i_data  (s_dd),
        .i_coef  (s_coef),
        .o_valid (s_bv),
        .o_data  (s_bd)
    );

    // A result leaves the last stage only on a cycle the pipeline advances.
    assign s_take     = r_out_v && !i_stall;
    assign s_arrive   = s_bv && s_en;
    assign s_out_free = !r_out_v || s_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (s_out_free) begin
            // drain the skid first; it is empty whenever a result arrives
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= s_arrive;
            end
        end else if (s_arrive) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_free) begin
            r_out <= r_skid_v ? r_skid : s_bd;
        end else if (s_arrive) begin
            r_skid <= s_bd;
        end
    end

    assign o_valid             = r_out_v;
    assign o_temp_centidegrees = r_out.temp;
    assign o_pressure_q24_8    = r_out.press;
    assign o_divisor_zero      = r_out.zero;

endmodule
